[design/memt_pkg.sv]
// shared types and constants for the midi event match table
package memt_pkg;

  localparam int unsigned Entries = 64;
  localparam int unsigned IdxW = $clog2(Entries);
  localparam int unsigned CntW = $clog2(Entries + 1);
  localparam logic [6:0] CcAllNotesOff = 7'd123;
  localparam logic [3:0] StatusCc = 4'hB;
  localparam logic [3:0] TypeProgChange = 4'd4;
  localparam logic [3:0] TypePitchBend = 4'd6;
  localparam logic [3:0] TypeCcMax = 4'd3;
  localparam logic [3:0] TypeAfterTouch = 4'd5;

  typedef enum logic [1:0] {
    ActAdd = 2'd0,
    ActMatch = 2'd1,
    ActSearch = 2'd2,
    ActClear = 2'd3
  } action_e;

  typedef struct packed {
    logic [15:0] id;
    logic [3:0] etype;
    logic [7:0] first;
    logic [7:0] second;
    logic present;
    logic [15:0] ports;
    logic [15:0] rmin;
    logic [15:0] rmax;
  } entry_t;

  typedef struct packed {
    action_e action;
    logic [15:0] id;
    logic [7:0] status;
    logic [6:0] d1;
    logic [6:0] d2;
    logic noff;
    logic add_err;
  } cmd_t;

endpackage

[design/midi_event_match_table.sv]
// top level of the midi event match table
//  channel | signals                          | direction
//  cmd     | start, busy (out), action_i .. data2_i | in
//  result  | done_o, hit_o .. last_o          | out
//  config  | cfg_we_i, cfg_data_i             | in
// add, clear and scans of an empty table give a single result
// match and search read each stored entry in turn through the SRead and SEval states;
// search ends at the first entry whose id matches
// busy stays high through the last result and drops in the cycle after, so the next
// item is taken only after the last result
// reset empties the table; results cannot be stalled.
module midi_event_match_table (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  logic cfg_we_i,
  input  logic [4:0] cfg_data_i,
  input  logic [1:0] action_i,
  input  logic [15:0] entry_id_i,
  input  logic [3:0] event_type_i,
  input  logic [7:0] stream_first_i,
  input  logic [7:0] stream_second_i,
  input  logic stream_present_i,
  input  logic [15:0] port_mask_i,
  input  logic signed [15:0] range_min_i,
  input  logic signed [15:0] range_max_i,
  input  logic [7:0] midi_status_i,
  input  logic [6:0] midi_data1_i,
  input  logic [6:0] midi_data2_i,
  output logic done_o,
  output logic hit_o,
  output logic [15:0] found_id_o,
  output logic [13:0] event_value_o,
  output logic [3:0] found_type_o,
  output logic [15:0] found_ports_o,
  output logic signed [15:0] found_min_o,
  output logic signed [15:0] found_max_o,
  output logic notes_off_o,
  output logic add_error_o,
  output logic last_o
);
  logic [4:0] chan_q;
  memt_pkg::entry_t ent, wr_data;
  logic wr_en, q_valid, q_pop;
  logic [memt_pkg::IdxW-1:0] wr_addr;
  logic [memt_pkg::CntW-1:0] count;
  memt_pkg::cmd_t q_cmd;
  logic [15:0] fmin, fmax;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) chan_q <= '0;
    else if (cfg_we_i) chan_q <= cfg_data_i;
  end

  assign ent = '{id: entry_id_i, etype: event_type_i, first: stream_first_i,
                 second: stream_second_i, present: stream_present_i, ports: port_mask_i,
                 rmin: range_min_i, rmax: range_max_i};

  memt_front u_front (
    .clk_i, .rst_ni, .start, .busy, .notes_off_channel_i(chan_q), .action_i,
    .entry_i(ent), .midi_status_i, .midi_data1_i, .midi_data2_i,
    .wr_en_o(wr_en), .wr_addr_o(wr_addr), .wr_data_o(wr_data), .count_o(count),
    .q_valid_o(q_valid), .q_cmd_o(q_cmd), .q_pop_i(q_pop)
  );

  memt_back u_back (
    .clk_i, .rst_ni, .wr_en_i(wr_en), .wr_addr_i(wr_addr), .wr_data_i(wr_data),
    .count_i(count), .q_valid_i(q_valid), .q_cmd_i(q_cmd), .q_pop_o(q_pop),
    .done_o, .hit_o, .found_id_o, .event_value_o, .found_type_o, .found_ports_o,
    .found_min_o(fmin), .found_max_o(fmax), .notes_off_o, .add_error_o, .last_o
  );

  assign found_min_o = fmin;
  assign found_max_o = fmax;
endmodule

[design/memt_front.sv]
// front end: accepts items, updates the entry count, writes adds, queues every command for the back end
module memt_front (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  logic [4:0] notes_off_channel_i,
  input  logic [1:0] action_i,
  input  memt_pkg::entry_t entry_i,
  input  logic [7:0] midi_status_i,
  input  logic [6:0] midi_data1_i,
  input  logic [6:0] midi_data2_i,
  output logic wr_en_o,
  output logic [memt_pkg::IdxW-1:0] wr_addr_o,
  output memt_pkg::entry_t wr_data_o,
  output logic [memt_pkg::CntW-1:0] count_o,
  output logic q_valid_o,
  output memt_pkg::cmd_t q_cmd_o,
  input  logic q_pop_i
);
  logic [memt_pkg::CntW-1:0] count_q, count_d;
  logic q_valid_q;
  memt_pkg::cmd_t q_cmd_q;
  logic acc, full, noff;

  assign busy = q_valid_q;
  assign acc = start && !busy;
  assign full = (count_q == memt_pkg::CntW'(memt_pkg::Entries));
  assign noff = (midi_status_i[7:4] == memt_pkg::StatusCc) && (notes_off_channel_i != 5'd0)
    && ({1'b0, midi_status_i[3:0]} == notes_off_channel_i - 5'd1)
    && (midi_data1_i == memt_pkg::CcAllNotesOff);

  assign wr_en_o = acc && (memt_pkg::action_e'(action_i) == memt_pkg::ActAdd) && !full;
  assign wr_addr_o = count_q[memt_pkg::IdxW-1:0];
  assign wr_data_o = entry_i;

  always_comb begin
    count_d = count_q;
    if (wr_en_o) count_d = count_q + memt_pkg::CntW'(1);
    else if (acc && memt_pkg::action_e'(action_i) == memt_pkg::ActClear)
      count_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      q_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (acc) q_valid_q <= 1'b1;
      else if (q_pop_i) q_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      q_cmd_q.action <= memt_pkg::action_e'(action_i);
      q_cmd_q.id <= entry_i.id;
      q_cmd_q.status <= midi_status_i;
      q_cmd_q.d1 <= midi_data1_i;
      q_cmd_q.d2 <= midi_data2_i;
      q_cmd_q.noff <= noff && (memt_pkg::action_e'(action_i) == memt_pkg::ActMatch);
      q_cmd_q.add_err <= full;
    end
  end

  assign count_o = count_q;
  assign q_valid_o = q_valid_q;
  assign q_cmd_o = q_cmd_q;
endmodule

[design/memt_back.sv]
// back end: entry memory and scan engine producing results
module memt_back (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_en_i,
  input  logic [memt_pkg::IdxW-1:0] wr_addr_i,
  input  memt_pkg::entry_t wr_data_i,
  input  logic [memt_pkg::CntW-1:0] count_i,
  input  logic q_valid_i,
  input  memt_pkg::cmd_t q_cmd_i,
  output logic q_pop_o,
  output logic done_o,
  output logic hit_o,
  output logic [15:0] found_id_o,
  output logic [13:0] event_value_o,
  output logic [3:0] found_type_o,
  output logic [15:0] found_ports_o,
  output logic [15:0] found_min_o,
  output logic [15:0] found_max_o,
  output logic notes_off_o,
  output logic add_error_o,
  output logic last_o
);
  typedef enum logic [1:0] {SIdle, SRead, SEval} state_e;
  state_e state_q;
  memt_pkg::entry_t mem [memt_pkg::Entries];
  memt_pkg::entry_t rd_q;
  logic [memt_pkg::CntW-1:0] idx_q, cnt_q;
  logic any_q;
  logic pend_q;
  memt_pkg::entry_t pend_e_q;
  logic [13:0] pend_v_q;
  logic m;
  logic [13:0] v;
  logic found;
  logic more;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
    rd_q <= mem[idx_q[memt_pkg::IdxW-1:0]];
  end

  always_comb begin
    m = rd_q.present && (rd_q.first == q_cmd_i.status);
    v = {7'd0, q_cmd_i.d2};
    if (rd_q.etype <= memt_pkg::TypeCcMax) begin
      m = m && (q_cmd_i.d1 == rd_q.second[6:0]) && (rd_q.second[7] == 1'b0);
    end else if (rd_q.etype <= memt_pkg::TypeAfterTouch) begin
      v = {7'd0, q_cmd_i.d1};
    end else if (rd_q.etype == memt_pkg::TypePitchBend) begin
      v = {q_cmd_i.d2, q_cmd_i.d1};
    end else begin
      m = 1'b0;
    end
    found = rd_q.id == q_cmd_i.id;
  end

  assign more = (idx_q + memt_pkg::CntW'(1)) < cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      q_pop_o <= 1'b0;
      done_o <= 1'b0;
      last_o <= 1'b0;
      hit_o <= 1'b0;
      found_id_o <= '0;
      event_value_o <= '0;
      found_type_o <= '0;
      found_ports_o <= '0;
      found_min_o <= '0;
      found_max_o <= '0;
      notes_off_o <= 1'b0;
      add_error_o <= 1'b0;
      pend_q <= 1'b0;
      pend_e_q <= '0;
      pend_v_q <= '0;
      any_q <= 1'b0;
      idx_q <= '0;
      cnt_q <= '0;
    end else begin
      q_pop_o <= 1'b0;
      done_o <= 1'b0;
      last_o <= 1'b0;
      case (state_q)
        SIdle: begin
          if (q_valid_i && !q_pop_o && !pend_q) begin
            if ((q_cmd_i.action == memt_pkg::ActMatch || q_cmd_i.action == memt_pkg::ActSearch)
                && count_i != '0) begin
              idx_q <= '0;
              cnt_q <= count_i;
              any_q <= 1'b0;
              pend_q <= 1'b0;
              state_q <= SRead;
            end else begin
              done_o <= 1'b1;
              last_o <= 1'b1;
              hit_o <= 1'b0;
              found_id_o <= '0; event_value_o <= '0; found_type_o <= '0;
              found_ports_o <= '0; found_min_o <= '0; found_max_o <= '0;
              notes_off_o <= q_cmd_i.noff;
              add_error_o <= (q_cmd_i.action == memt_pkg::ActAdd) && q_cmd_i.add_err;
              q_pop_o <= 1'b1;
            end
          end
        end
        SRead: state_q <= SEval;
        SEval: begin
          if (q_cmd_i.action == memt_pkg::ActSearch) begin
            if (found || !more) begin
              done_o <= 1'b1; last_o <= 1'b1; hit_o <= found;
              found_id_o <= found ? rd_q.id : '0;
              found_type_o <= found ? rd_q.etype : '0;
              found_ports_o <= found ? rd_q.ports : '0;
              found_min_o <= found ? rd_q.rmin : '0;
              found_max_o <= found ? rd_q.rmax : '0;
              event_value_o <= '0; notes_off_o <= 1'b0; add_error_o <= 1'b0;
              q_pop_o <= 1'b1;
              state_q <= SIdle;
            end else begin
              idx_q <= idx_q + memt_pkg::CntW'(1);
              state_q <= SRead;
            end
          end else begin
            // emit previous hit once the next one (or end) is known
            if (pend_q && (m || !more)) begin
              done_o <= 1'b1; hit_o <= 1'b1;
              last_o <= !m && !more;
              found_id_o <= pend_e_q.id; found_type_o <= pend_e_q.etype;
              found_ports_o <= pend_e_q.ports; found_min_o <= pend_e_q.rmin;
              found_max_o <= pend_e_q.rmax; event_value_o <= pend_v_q;
              notes_off_o <= q_cmd_i.noff; add_error_o <= 1'b0;
            end
            if (m) begin
              pend_q <= 1'b1; pend_e_q <= rd_q; pend_v_q <= v; any_q <= 1'b1;
            end
            if (more) begin
              idx_q <= idx_q + memt_pkg::CntW'(1);
              state_q <= SRead;
            end else if (m) begin
              pend_q <= 1'b1;
              state_q <= SIdle;
              cnt_q <= '0;
            end else begin
              if (!pend_q && !any_q) begin
                done_o <= 1'b1; last_o <= 1'b1; hit_o <= 1'b0;
                found_id_o <= '0; event_value_o <= '0; found_type_o <= '0;
                found_ports_o <= '0; found_min_o <= '0; found_max_o <= '0;
                notes_off_o <= q_cmd_i.noff; add_error_o <= 1'b0;
              end
              pend_q <= 1'b0;
              q_pop_o <= 1'b1;
              state_q <= SIdle;
            end
          end
        end
        default: state_q <= SIdle;
      endcase
      // flush final pending hit after the scan ended on a match
      if (state_q == SIdle && pend_q) begin
        done_o <= 1'b1; last_o <= 1'b1; hit_o <= 1'b1;
        found_id_o <= pend_e_q.id; found_type_o <= pend_e_q.etype;
        found_ports_o <= pend_e_q.ports; found_min_o <= pend_e_q.rmin;
        found_max_o <= pend_e_q.rmax; event_value_o <= pend_v_q;
        notes_off_o <= q_cmd_i.noff; add_error_o <= 1'b0;
        pend_q <= 1'b0;
        q_pop_o <= 1'b1;
      end
    end
  end
endmodule

[design/memt_checker.sv]
// port-level checks for the midi event match table
module memt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic hit_o,
  input logic add_error_o,
  input logic last_o
);
  a_last_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> done_o) else $error("last without done");
  a_err_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && add_error_o |-> !hit_o) else $error("add error with hit");
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("busy not raised");
  a_no_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !done_o) else $error("result while idle");
endmodule

bind midi_event_match_table memt_checker u_memt_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o, .hit_o, .add_error_o, .last_o
);

[tb/sv/memt_checker.sv]
// checker that predicts and compares the match table results
`timescale 1ns / 1ps
module memt_scoreboard
  import memt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  logic busy,
  input  logic cfg_we_i,
  input  logic [4:0] cfg_data_i,
  input  logic [1:0] action_i,
  input  logic [15:0] entry_id_i,
  input  logic [3:0] event_type_i,
  input  logic [7:0] stream_first_i,
  input  logic [7:0] stream_second_i,
  input  logic stream_present_i,
  input  logic [15:0] port_mask_i,
  input  logic [15:0] range_min_i,
  input  logic [15:0] range_max_i,
  input  logic [7:0] midi_status_i,
  input  logic [6:0] midi_data1_i,
  input  logic [6:0] midi_data2_i,
  input  logic done_o,
  input  logic hit_o,
  input  logic [15:0] found_id_o,
  input  logic [13:0] event_value_o,
  input  logic [3:0] found_type_o,
  input  logic [15:0] found_ports_o,
  input  logic [15:0] found_min_o,
  input  logic [15:0] found_max_o,
  input  logic notes_off_o,
  input  logic add_error_o,
  input  logic last_o,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic hit;
    logic [15:0] id;
    logic [13:0] value;
    logic [3:0] etype;
    logic [15:0] ports;
    logic [15:0] rmin;
    logic [15:0] rmax;
    logic noff;
    logic aerr;
    logic last;
  } match_res_t;

  entry_t     table_mdl [Entries];
  int         entry_cnt;
  logic [4:0] noff_chan;
  match_res_t result_q [$];

  function automatic match_res_t res_of(entry_t e, logic [13:0] v, logic nf);
    match_res_t r;
    r = '0;
    r.hit = 1'b1;
    r.id = e.id;
    r.value = v;
    r.etype = e.etype;
    r.ports = e.ports;
    r.rmin = e.rmin;
    r.rmax = e.rmax;
    r.noff = nf;
    return r;
  endfunction

  task automatic predict_item();
    match_res_t r;
    entry_t e;
    logic nf;
    logic [13:0] v;
    bit ok;
    int n;
    r = '0;
    r.last = 1'b1;
    case (action_e'(action_i))
      ActAdd: begin
        if (entry_cnt >= Entries) begin
          r.aerr = 1'b1;
        end else begin
          e.id = entry_id_i;
          e.etype = event_type_i;
          e.first = stream_first_i;
          e.second = stream_second_i;
          e.present = stream_present_i;
          e.ports = port_mask_i;
          e.rmin = range_min_i;
          e.rmax = range_max_i;
          table_mdl[entry_cnt] = e;
          entry_cnt++;
        end
        result_q.push_back(r);
      end
      ActClear: begin
        entry_cnt = 0;
        result_q.push_back(r);
      end
      ActSearch: begin
        for (int i = 0; i < entry_cnt; i++) begin
          if (table_mdl[i].id == entry_id_i) begin
            r = res_of(table_mdl[i], '0, 1'b0);
            r.last = 1'b1;
            break;
          end
        end
        result_q.push_back(r);
      end
      default: begin
        nf = midi_status_i[7:4] == StatusCc && noff_chan != 5'd0 && noff_chan <= 5'd16 &&
             {1'b0, midi_status_i[3:0]} == noff_chan - 5'd1 &&
             midi_data1_i == CcAllNotesOff;
        n = 0;
        for (int i = 0; i < entry_cnt; i++) begin
          e = table_mdl[i];
          ok = e.present && e.first == midi_status_i;
          v = '0;
          if (e.etype <= TypeCcMax) begin
            ok = ok && {1'b0, midi_data1_i} == e.second;
            v = {7'd0, midi_data2_i};
          end else if (e.etype <= TypeAfterTouch) begin
            v = {7'd0, midi_data1_i};
          end else if (e.etype == TypePitchBend) begin
            v = {midi_data2_i, midi_data1_i};
          end else begin
            ok = 1'b0;
          end
          if (ok) begin
            result_q.push_back(res_of(e, v, nf));
            n++;
          end
        end
        if (n == 0) begin
          r.noff = nf;
          result_q.push_back(r);
        end else begin
          result_q[$].last = 1'b1;
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    match_res_t got, exp_r;
    if (!rst_ni) begin
      entry_cnt <= 0;
      noff_chan <= '0;
      fail_count <= 0;
      result_q.delete();
    end else begin
      if (done_o) begin
        got = {hit_o, found_id_o, event_value_o, found_type_o, found_ports_o,
               found_min_o, found_max_o, notes_off_o, add_error_o, last_o};
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = result_q.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch expected hit=%b id=%h val=%h typ=%h ports=%h min=%h max=%h nf=%b ae=%b last=%b",
                     $time, exp_r.hit, exp_r.id, exp_r.value, exp_r.etype, exp_r.ports,
                     exp_r.rmin, exp_r.rmax, exp_r.noff, exp_r.aerr, exp_r.last);
            $display("%0t: mismatch actual   hit=%b id=%h val=%h typ=%h ports=%h min=%h max=%h nf=%b ae=%b last=%b",
                     $time, got.hit, got.id, got.value, got.etype, got.ports,
                     got.rmin, got.rmax, got.noff, got.aerr, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_we_i) noff_chan <= cfg_data_i;
      if (start && !busy) predict_item();
    end
  end

  assign pending = result_q.size();

endmodule

[tb/sv/tb.sv]
// testbench top: stimulus, configuration phases and verdict
`timescale 1ns / 1ps
module tb;
  import memt_pkg::*;

  localparam int WatchLimit = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cfg_we_i = 1'b0;
  logic [4:0] cfg_data_i = '0;
  logic [1:0] action_i = '0;
  logic [15:0] entry_id_i = '0;
  logic [3:0] event_type_i = '0;
  logic [7:0] stream_first_i = '0;
  logic [7:0] stream_second_i = '0;
  logic stream_present_i = 1'b0;
  logic [15:0] port_mask_i = '0;
  logic [15:0] range_min_i = '0;
  logic [15:0] range_max_i = '0;
  logic [7:0] midi_status_i = '0;
  logic [6:0] midi_data1_i = '0;
  logic [6:0] midi_data2_i = '0;
  logic done_o, hit_o, notes_off_o, add_error_o, last_o;
  logic [15:0] found_id_o, found_ports_o, found_min_o, found_max_o;
  logic [13:0] event_value_o;
  logic [3:0] found_type_o;
  int fail_count, pending, idle_cycles;
  logic [7:0] status_pool [8];
  logic [15:0] id_pool [8];

  always #2 clk_i = ~clk_i;

  midi_event_match_table u_dut (.*);
  memt_scoreboard u_chk (.*);

  always @(posedge clk_i) begin
    if (done_o || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic issue(action_e act, logic [15:0] id, logic [3:0] et,
                       logic [7:0] sf, logic [7:0] ss, logic sp,
                       logic [7:0] st, logic [6:0] d1, logic [6:0] d2);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    action_i <= act;
    entry_id_i <= id;
    event_type_i <= et;
    stream_first_i <= sf;
    stream_second_i <= ss;
    stream_present_i <= sp;
    port_mask_i <= 16'($urandom);
    range_min_i <= 16'($urandom);
    range_max_i <= 16'($urandom);
    midi_status_i <= st;
    midi_data1_i <= d1;
    midi_data2_i <= d2;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (140) @(posedge clk_i);
  endtask

  task automatic set_channel(logic [4:0] ch);
    settle();
    cfg_we_i <= 1'b1;
    cfg_data_i <= ch;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_item();
    int k;
    logic [7:0] st;
    logic [6:0] d1;
    k = $urandom_range(0, 99);
    st = ($urandom_range(0, 9) == 0) ? 8'($urandom) : status_pool[$urandom_range(0, 7)];
    d1 = ($urandom_range(0, 2) == 0) ? 7'($urandom_range(0, 3)) :
         (($urandom_range(0, 4) == 0) ? CcAllNotesOff : 7'($urandom));
    if (k < 35)
      issue(ActAdd, id_pool[$urandom_range(0, 7)] ^ 16'($urandom_range(0, 1) << 15),
            4'($urandom_range(0, 15) < 12 ? $urandom_range(0, 6) : $urandom_range(7, 15)),
            st, 8'($urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, 3)),
            1'($urandom_range(0, 5) != 0), 8'($urandom), 7'($urandom), 7'($urandom));
    else if (k < 75)
      issue(ActMatch, 16'($urandom), 4'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
            st, d1, 7'($urandom));
    else if (k < 95)
      issue(ActSearch, ($urandom_range(0, 4) == 0) ? 16'($urandom) : id_pool[$urandom_range(0, 7)],
            4'($urandom), 8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
            7'($urandom), 7'($urandom));
    else
      issue(ActClear, 16'($urandom), 4'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
            8'($urandom), 7'($urandom), 7'($urandom));
  endtask

  initial begin
    for (int i = 0; i < 8; i++) begin
      status_pool[i] = {4'($urandom_range(8, 14)), 4'($urandom)};
      id_pool[i] = 16'($urandom);
    end
    status_pool[0] = 8'hB3;
    id_pool[0] = 16'hFFFF;
    id_pool[1] = 16'h0000;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_channel(5'd4);
    // directed: empty table, types 0 to 7 and 15, extremes, notes off
    issue(ActSearch, 16'h1234, 0, 0, 0, 0, 0, 0, 0);
    issue(ActMatch, 0, 0, 0, 0, 0, 8'hB3, CcAllNotesOff, 7'h7F);
    for (int t = 0; t < 8; t++)
      issue(ActAdd, 16'(t), 4'(t), 8'h90, 8'h40, 1'b1, 0, 0, 0);
    issue(ActAdd, 16'hFFFF, 4'hF, 8'h90, 8'h40, 1'b1, 0, 0, 0);
    issue(ActAdd, 16'h0000, 4'd1, 8'h90, 8'h40, 1'b0, 0, 0, 0);
    issue(ActAdd, 16'h8000, 4'd3, 8'hB3, 8'd123, 1'b1, 0, 0, 0);
    issue(ActMatch, 0, 0, 0, 0, 0, 8'h90, 7'h40, 7'h7F);
    issue(ActMatch, 0, 0, 0, 0, 0, 8'h90, 7'h7F, 7'h7F);
    issue(ActMatch, 0, 0, 0, 0, 0, 8'h90, 7'h00, 7'h00);
    issue(ActMatch, 0, 0, 0, 0, 0, 8'hB3, CcAllNotesOff, 7'h55);
    issue(ActSearch, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0);
    issue(ActSearch, 16'h0000, 0, 0, 0, 0, 0, 0, 0);
    issue(ActClear, 0, 0, 0, 0, 0, 0, 0, 0);
    issue(ActSearch, 16'h0003, 0, 0, 0, 0, 0, 0, 0);
    // fill the table to overflow
    for (int i = 0; i < 66; i++)
      issue(ActAdd, 16'($urandom), 4'($urandom_range(0, 6)), 8'hE0, 8'($urandom_range(0, 1)),
            1'b1, 0, 0, 0);
    issue(ActMatch, 0, 0, 0, 0, 0, 8'hE0, 7'h01, 7'h7F);
    issue(ActClear, 0, 0, 0, 0, 0, 0, 0, 0);
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_channel(5'd0);
        1: set_channel(5'd16);
        2: set_channel(5'd1);
        3: set_channel(5'd31);
        default: set_channel(5'd4);
      endcase
      repeat (64) random_item();
    end
    settle();
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
